// ----- rtl/positional_insert_delete_list_unit_assert.svh -----
// ----------------------------------------------------------------------------
// positional_insert_delete_list_unit assertion macros
// Shared wrappers for the concurrent checks of the list unit. Each macro is
// used in a module that has i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_LIST_UNIT_ASSERT_SVH

// Check that is switched off while reset is held.
`define PIDL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that also holds while reset is held.
`define PIDL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/pidl_pkg.sv -----
// ----------------------------------------------------------------------------
// pidl_pkg
// Types, sizes and codes shared by the positional insert/delete list unit.
// ----------------------------------------------------------------------------
package pidl_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 2;
    localparam int OUT_LEN_W = 5;

    // Count must hold CAPACITY itself; an index covers 0..CAPACITY-1.
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    // Compare width: room for position and count + 1 without wrap.
    localparam int CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

    localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT_AT  = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_END = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_AT  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_AT    = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic [1:0]        mode;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

    // Per-request response from the controller.
    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [OUT_LEN_W-1:0] list_length;
        logic                 rd_en;
        logic [IDX_W-1:0]     rd_index;
    } t_rsp;

endpackage

// ----- rtl/positional_insert_delete_list_unit.sv -----
// ----------------------------------------------------------------------------
// positional_insert_delete_list_unit
// Bounded ordered list of signed 32-bit words with positional insert/remove.
// ----------------------------------------------------------------------------
// Usage: a request word (operation, 1-based position, item value) enters on
// i_valid and is taken at a clock edge where o_stall is low. Each request
// produces exactly one result word (status, list length after the request,
// read value) on o_valid, taken at an edge where i_stall is low.
// The result is registered at the edge that accepts the request. Throughput
// is one request per cycle while the receiver does not stall; the bound is
// the length counter in the controller, which every request reads and updates.
// The entries live in a chain of cells, one word each. On an insert every
// cell above the position takes its lower neighbor's word while the cell
// at the position loads the new value; on a positional remove every cell at
// or above the position takes its upper neighbor's word. All cells move in the
// same cycle, so no request takes longer than another.
// Reset clears the length and the output valid; the cell contents are not
// cleared, since only positions below the length are ever read.
// While the receiver stalls a pending result, o_stall is raised and the
// result word is held unchanged until it is taken.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_unit
    import pidl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_item_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [STAT_W-1:0]        o_status,
    output logic [OUT_LEN_W-1:0]     o_list_length,
    output logic signed [DATA_W-1:0] o_read_value
);

`include "positional_insert_delete_list_unit_assert.svh"

    logic                 w_accept;
    t_cell_ctl            w_cell_ctl;
    t_rsp                 w_rsp;
    logic [LEN_W-1:0]     w_count;
    logic [DATA_W-1:0]    w_cell_data [CAPACITY];
    logic [DATA_W-1:0]    w_read_word;

    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_status;
    logic [OUT_LEN_W-1:0] r_list_length;
    logic [DATA_W-1:0]    r_read_value;

    // A new request may enter whenever the output register is empty or is
    // being emptied in this same cycle.
    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    pidl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_cell_ctl   (w_cell_ctl),
        .o_rsp        (w_rsp),
        .o_count      (w_count)
    );

    // The chain: each cell sees its lower and upper neighbor. The bottom
    // cell never shifts up from below, and the top cell's upper input is
    // its own word, since a remove leaves that slot outside the list.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cell_data[g];
        end else begin : g_inner
            assign w_right = w_cell_data[g+1];
        end

        pidl_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_ctl   (w_cell_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell_data[g])
        );
    end

    // A read picks the addressed cell; every other result reads as zero.
    assign w_read_word = w_rsp.rd_en ? w_cell_data[w_rsp.rd_index] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= w_rsp.status;
            r_list_length <= w_rsp.list_length;
            r_read_value  <= w_read_word;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_list_length = r_list_length;
    assign o_read_value  = r_read_value;

    `PIDL_ASSERT(a_count_bound, w_count <= LEN_W'(CAPACITY), "list length beyond capacity")
    `PIDL_ASSERT(a_len_tracks, o_valid |-> (o_list_length == OUT_LEN_W'(w_count)), "result length differs from count")
    `PIDL_ASSERT(a_err_zero, (o_valid && (o_status != ST_OK)) |-> (o_read_value == '0), "error result carries data")
    `PIDL_ASSERT(a_accept_valid, w_accept |=> o_valid, "accepted request gave no result")

endmodule

// ----- rtl/pidl_cell.sv -----
// ----------------------------------------------------------------------------
// pidl_cell
// One list slot. Holds, loads the broadcast value, or takes a neighbor's word.
// ----------------------------------------------------------------------------
module pidl_cell
    import pidl_pkg::*;
(
    input  logic              i_clk,
    input  logic [IDX_W-1:0]  i_index,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.mode)
            CELL_INS: begin
                if (i_index == i_ctl.index) begin
                    n_data = i_ctl.value;
                end else if (i_index > i_ctl.index) begin
                    n_data = i_left;
                end
            end
            CELL_DEL: begin
                if (i_index >= i_ctl.index) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- rtl/pidl_ctrl.sv -----
// ----------------------------------------------------------------------------
// pidl_ctrl
// Request decoder and length counter: checks limits, sets the cell command.
// ----------------------------------------------------------------------------
module pidl_ctrl
    import pidl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [POS_W-1:0]  i_position,
    input  logic [DATA_W-1:0] i_item_value,
    output t_cell_ctl         o_cell_ctl,
    output t_rsp              o_rsp,
    output logic [LEN_W-1:0]  o_count
);

    logic [LEN_W-1:0] r_count;
    logic [LEN_W-1:0] n_count;

    logic             w_full;
    logic             w_empty;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_cnt;
    logic [CMP_W-1:0] w_pos_m1;
    logic             w_ins_ok;
    logic             w_at_ok;
    logic [IDX_W-1:0] w_pos_idx;
    logic [IDX_W-1:0] w_end_idx;

    assign w_full    = (r_count == LEN_W'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_pos     = CMP_W'(i_position);
    assign w_cnt     = CMP_W'(r_count);
    assign w_pos_m1  = w_pos - CMP_W'(1);
    assign w_ins_ok  = (w_pos != '0) && (w_pos <= w_cnt + CMP_W'(1));
    assign w_at_ok   = (w_pos != '0) && (w_pos <= w_cnt);
    assign w_pos_idx = w_pos_m1[IDX_W-1:0];
    assign w_end_idx = IDX_W'(r_count);

    always_comb begin
        n_count          = r_count;
        o_cell_ctl.mode  = CELL_HOLD;
        o_cell_ctl.index = w_pos_idx;
        o_cell_ctl.value = i_item_value;
        o_rsp.status     = ST_OK;
        o_rsp.rd_en      = 1'b0;
        o_rsp.rd_index   = w_pos_idx;

        unique case (i_operation)
            OP_APPEND: begin
                if (w_full) begin
                    o_rsp.status = ST_FULL;
                end else begin
                    // An append is an insert just past the last entry.
                    o_cell_ctl.mode  = CELL_INS;
                    o_cell_ctl.index = w_end_idx;
                    n_count          = r_count + LEN_W'(1);
                end
            end
            OP_INSERT_AT: begin
                if (w_full) begin
                    o_rsp.status = ST_FULL;
                end else if (!w_ins_ok) begin
                    o_rsp.status = ST_RANGE;
                end else begin
                    o_cell_ctl.mode = CELL_INS;
                    n_count         = r_count + LEN_W'(1);
                end
            end
            OP_REMOVE_END: begin
                if (w_empty) begin
                    o_rsp.status = ST_EMPTY;
                end else begin
                    n_count = r_count - LEN_W'(1);
                end
            end
            OP_REMOVE_AT: begin
                if (w_empty) begin
                    o_rsp.status = ST_EMPTY;
                end else if (!w_at_ok) begin
                    o_rsp.status = ST_RANGE;
                end else begin
                    o_cell_ctl.mode = CELL_DEL;
                    n_count         = r_count - LEN_W'(1);
                end
            end
            OP_READ_AT: begin
                if (w_empty) begin
                    o_rsp.status = ST_EMPTY;
                end else if (!w_at_ok) begin
                    o_rsp.status = ST_RANGE;
                end else begin
                    o_rsp.rd_en = 1'b1;
                end
            end
            default: begin
                o_rsp.status = ST_OK;
            end
        endcase

        if (!i_accept) begin
            o_cell_ctl.mode = CELL_HOLD;
            n_count         = r_count;
        end
        o_rsp.list_length = OUT_LEN_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

// ----- tb/tb_positional_insert_delete_list_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_insert_delete_list_unit
// Self-checking bench for the bounded positional insert/remove list unit.
// ----------------------------------------------------------------------------
// A short table of directed request words runs first. It covers the empty,
// full and out-of-range errors, the unused operation codes, the extreme
// positions and values, inserts at the front, middle and end, and removes at
// the front and end. Results that can be read straight off the list contents
// are typed into the table. Every other row, and about 1200 random words after
// it, is checked against a behavioral copy of the list kept inside the bench.
// Both handshake sides idle and stall at random. One long receiver hold-off
// makes the unit back up and stall its input.
// ----------------------------------------------------------------------------
module tb_positional_insert_delete_list_unit;
    import pidl_pkg::*;

    // Operation codes that the unit treats as a no-op with an OK status.
    localparam logic [OP_W-1:0] OP_UNUSED_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam int RANDOM_WORDS = 1200;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AFTER   = 400;
    localparam int N_DIRECTED   = 25;

    // One result word as the unit reports it.
    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [OUT_LEN_W-1:0] length;
        logic [DATA_W-1:0]    read;
    } t_list_result;

    // A result typed into the directed table overrides the computed one.
    typedef struct packed {
        logic         pinned;
        t_list_result result;
    } t_list_pin;

    // One row of the directed table. A row repeated more than once sends
    // random values and is always checked against the computed result.
    typedef struct {
        logic [OP_W-1:0]      op;
        logic [POS_W-1:0]     pos;
        logic [DATA_W-1:0]    value;
        int                   reps;
        logic                 pinned;
        logic [STAT_W-1:0]    status;
        logic [OUT_LEN_W-1:0] length;
        logic [DATA_W-1:0]    read;
    } t_stim_row;

    t_stim_row directed_rows [N_DIRECTED] = '{
        // Reads, removes and out-of-range inserts on the empty list.
        '{OP_READ_AT,    5'd1,  32'h0,         1,  1'b1, ST_EMPTY, 5'd0,  32'h0},
        '{OP_REMOVE_END, 5'd0,  32'h0,         1,  1'b1, ST_EMPTY, 5'd0,  32'h0},
        '{OP_REMOVE_AT,  5'd0,  32'h0,         1,  1'b1, ST_EMPTY, 5'd0,  32'h0},
        '{OP_INSERT_AT,  5'd0,  32'h5,         1,  1'b1, ST_RANGE, 5'd0,  32'h0},
        '{OP_INSERT_AT,  5'd2,  32'h5,         1,  1'b1, ST_RANGE, 5'd0,  32'h0},
        // Build up with the extreme values, then fill to capacity.
        '{OP_INSERT_AT,  5'd1,  32'h7FFF_FFFF, 1,  1'b1, ST_OK,    5'd1,  32'h0},
        '{OP_APPEND,     5'd0,  32'h8000_0000, 1,  1'b1, ST_OK,    5'd2,  32'h0},
        '{OP_INSERT_AT,  5'd3,  32'hFFFF_FFFF, 1,  1'b1, ST_OK,    5'd3,  32'h0},
        '{OP_APPEND,     5'd0,  32'h0,         13, 1'b0, ST_OK,    5'd0,  32'h0},
        // Full list: fullness wins over the position.
        '{OP_APPEND,     5'd0,  32'h1,         1,  1'b1, ST_FULL,  5'd16, 32'h0},
        '{OP_INSERT_AT,  5'd1,  32'h1,         1,  1'b1, ST_FULL,  5'd16, 32'h0},
        '{OP_READ_AT,    5'd16, 32'h0,         1,  1'b0, ST_OK,    5'd0,  32'h0},
        '{OP_READ_AT,    5'd17, 32'h0,         1,  1'b1, ST_RANGE, 5'd16, 32'h0},
        '{OP_READ_AT,    5'd0,  32'h0,         1,  1'b1, ST_RANGE, 5'd16, 32'h0},
        '{OP_REMOVE_AT,  5'd31, 32'h0,         1,  1'b1, ST_RANGE, 5'd16, 32'h0},
        // Unused codes change nothing.
        '{OP_UNUSED_5,   5'd31, 32'hFFFF_FFFF, 1,  1'b1, ST_OK,    5'd16, 32'h0},
        '{OP_UNUSED_6,   5'd0,  32'h0,         1,  1'b1, ST_OK,    5'd16, 32'h0},
        '{OP_UNUSED_7,   5'd1,  32'h1,         1,  1'b1, ST_OK,    5'd16, 32'h0},
        // Remove the head; everything slides down one place.
        '{OP_REMOVE_AT,  5'd1,  32'h0,         1,  1'b1, ST_OK,    5'd15, 32'h0},
        '{OP_READ_AT,    5'd1,  32'h0,         1,  1'b1, ST_OK,    5'd15, 32'h8000_0000},
        '{OP_READ_AT,    5'd2,  32'h0,         1,  1'b1, ST_OK,    5'd15, 32'hFFFF_FFFF},
        '{OP_REMOVE_END, 5'd0,  32'h0,         1,  1'b1, ST_OK,    5'd14, 32'h0},
        // Insert in the middle and read it back.
        '{OP_INSERT_AT,  5'd2,  32'h1234_5678, 1,  1'b1, ST_OK,    5'd15, 32'h0},
        '{OP_READ_AT,    5'd2,  32'h0,         1,  1'b1, ST_OK,    5'd15, 32'h1234_5678},
        '{OP_INSERT_AT,  5'd31, 32'h0,         1,  1'b1, ST_RANGE, 5'd15, 32'h0}
    };

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [OP_W-1:0]          i_operation;
    logic [POS_W-1:0]         i_position;
    logic signed [DATA_W-1:0] i_item_value;
    logic                     o_valid;
    logic                     i_stall;
    logic [STAT_W-1:0]        o_status;
    logic [OUT_LEN_W-1:0]     o_list_length;
    logic signed [DATA_W-1:0] o_read_value;

    // Behavioral copy of the list, advanced on every accepted request word.
    logic [DATA_W-1:0] shadow_entries [CAPACITY];
    int                shadow_count = 0;

    t_list_result pending_results [$];
    t_list_pin    typed_results [$];
    int           fail_count    = 0;
    int           results_taken = 0;
    // Set by the sender for a stretch of the random part: no idling anywhere.
    bit           steady_run    = 1'b0;
    // Direction in which the random words push the list length.
    bit           growing       = 1'b1;

    positional_insert_delete_list_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_list_length (o_list_length),
        .o_read_value  (o_read_value)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one request word to the shadow list and returns its result.
    // Fullness and emptiness are tested before the position, as in the unit.
    function automatic t_list_result list_apply(input logic [OP_W-1:0] op,
                                                input logic [POS_W-1:0] pos,
                                                input logic [DATA_W-1:0] value);
        t_list_result res;
        int           p;
        int           i;
        p          = int'(pos);
        res.status = ST_OK;
        res.read   = '0;
        case (op)
            OP_APPEND: begin
                if (shadow_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_entries[shadow_count] = value;
                    shadow_count++;
                end
            end
            OP_INSERT_AT: begin
                if (shadow_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (p < 1 || p > shadow_count + 1) begin
                    res.status = ST_RANGE;
                end else begin
                    for (i = shadow_count; i > p - 1; i--) begin
                        shadow_entries[i] = shadow_entries[i-1];
                    end
                    shadow_entries[p-1] = value;
                    shadow_count++;
                end
            end
            OP_REMOVE_END: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_count--;
                end
            end
            OP_REMOVE_AT: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (p < 1 || p > shadow_count) begin
                    res.status = ST_RANGE;
                end else begin
                    for (i = p; i < shadow_count; i++) begin
                        shadow_entries[i-1] = shadow_entries[i];
                    end
                    shadow_count--;
                end
            end
            OP_READ_AT: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (p < 1 || p > shadow_count) begin
                    res.status = ST_RANGE;
                end else begin
                    res.read = shadow_entries[p-1];
                end
            end
            default: begin
            end
        endcase
        res.length = OUT_LEN_W'(shadow_count);
        return res;
    endfunction

    // Monitor. Both handshakes are sampled at the rising edge, before the
    // nonblocking updates of that edge land. The request side is handled first
    // so that the order holds even if a result appeared in the same cycle.
    always @(posedge i_clk) begin : watch_words
        t_list_pin    pin;
        t_list_result want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                pin  = (typed_results.size() != 0) ? typed_results.pop_front() : '0;
                want = list_apply(i_operation, i_position, i_item_value);
                if (pin.pinned) begin
                    want = pin.result;
                end
                pending_results.push_back(want);
            end
            if (o_valid && !i_stall) begin
                results_taken++;
                if (pending_results.size() == 0) begin
                    $error("result word with nothing outstanding: status %0d length %0d",
                           o_status, o_list_length);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_list_length !== want.length) begin
                        $error("list_length: expected %0d, got %0d",
                               want.length, o_list_length);
                        fail_count++;
                    end
                    if (o_read_value !== want.read) begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.read), o_read_value);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Receiver. It stalls at random, and once, after a few hundred results,
    // holds off for a long stretch so that the unit fills and stalls its input.
    initial begin : result_sink
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && results_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !steady_run && ($urandom_range(99) < 11);
            end
        end
    end

    // Offers one request word and returns at the edge that accepts it. A single
    // idle cycle comes first now and then. The expectation typed for the word,
    // if any, is queued before valid rises so the monitor finds it in order.
    task automatic offer_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] value, input t_list_pin pin);
        if (!steady_run && $urandom_range(99) < 11) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        typed_results.push_back(pin);
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_position   <= pos;
        i_item_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Random request word. Most words are well formed: a valid position for
    // the current length, with the mix leaning toward growing or shrinking
    // the list so that it swings between empty and full. The length hint may
    // lag the accepted words by one, which only blurs the choice of position.
    // The rest are noise: any code and any position.
    task automatic pick_random_word(output logic [OP_W-1:0] op,
                                    output logic [POS_W-1:0] pos,
                                    output logic [DATA_W-1:0] value);
        int len_hint;
        int roll;
        len_hint = shadow_count;
        value    = $urandom;
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7FFF_FFFF;
                2:       value = 32'h0;
                default: value = 32'hFFFF_FFFF;
            endcase
        end
        if ($urandom_range(99) < 8) begin
            op  = OP_W'($urandom_range(0, 7));
            pos = POS_W'($urandom_range(0, 31));
        end else begin
            // Turn around now and then at the ends, so that full and empty
            // errors also come from well-formed traffic.
            if (len_hint >= CAPACITY && $urandom_range(3) == 0) begin
                growing = 1'b0;
            end else if (len_hint == 0 && $urandom_range(3) == 0) begin
                growing = 1'b1;
            end else if ($urandom_range(29) == 0) begin
                growing = !growing;
            end
            roll = $urandom_range(99);
            if (growing) begin
                op = (roll < 35) ? OP_APPEND :
                     (roll < 65) ? OP_INSERT_AT :
                     (roll < 80) ? OP_READ_AT :
                     (roll < 90) ? OP_REMOVE_AT : OP_REMOVE_END;
            end else begin
                op = (roll < 30) ? OP_REMOVE_AT :
                     (roll < 55) ? OP_REMOVE_END :
                     (roll < 75) ? OP_READ_AT :
                     (roll < 90) ? OP_APPEND : OP_INSERT_AT;
            end
            if (op == OP_INSERT_AT) begin
                pos = POS_W'($urandom_range(1, len_hint + 1));
            end else begin
                pos = POS_W'($urandom_range(1, (len_hint > 0) ? len_hint : 1));
            end
        end
    endtask

    // Stimulus and end of run.
    initial begin : request_source
        t_list_pin         pin;
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
        int                r;
        int                k;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_operation  = OP_APPEND;
        i_position   = '0;
        i_item_value = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        for (r = 0; r < N_DIRECTED; r++) begin
            for (k = 0; k < directed_rows[r].reps; k++) begin
                pin.pinned        = directed_rows[r].pinned;
                pin.result.status = directed_rows[r].status;
                pin.result.length = directed_rows[r].length;
                pin.result.read   = directed_rows[r].read;
                value = (directed_rows[r].reps > 1) ? DATA_W'($urandom)
                                                    : directed_rows[r].value;
                offer_word(directed_rows[r].op, directed_rows[r].pos, value, pin);
            end
        end

        // Random part, with one stretch free of idling on both sides.
        pin = '0;
        for (r = 0; r < RANDOM_WORDS; r++) begin
            steady_run = (r >= 500 && r < 700);
            pick_random_word(op, pos, value);
            offer_word(op, pos, value, pin);
        end
        steady_run = 1'b0;
        i_valid <= 1'b0;

        // A word still waiting in the typed queue has not been predicted yet,
        // so both queues must drain before the run can settle.
        while (pending_results.size() != 0 || typed_results.size() != 0) begin
            @(posedge i_clk);
        end
        // The wait below catches any stray result word after the queues drain.
        repeat (4) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("positional_insert_delete_list_unit test passed");
        end else begin
            $display("positional_insert_delete_list_unit test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("positional_insert_delete_list_unit test failed");
        $finish;
    end

endmodule
